// ===== sv/dkpq_pkg.sv =====
package dkpq_pkg;

    localparam int DATE_W   = 23;
    localparam int TAG_W    = 8;
    localparam int AMT_W    = 24;
    localparam int DUE_W    = 25;
    localparam int CAP_W    = 5;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 5;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;

    // floor(x / 10) = (x * ceil(2^27 / 10)) >> 27, exact for any 24-bit x
    localparam int          PROD_W     = 2 * AMT_W;
    localparam int          FINE_SHIFT = 27;
    localparam int          QUO_W      = PROD_W - FINE_SHIFT;
    localparam logic [AMT_W-1:0] FINE_RECIP = 24'hCCCCCD;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [DATE_W-1:0] key;
        logic [TAG_W-1:0]  tag;
        logic [AMT_W-1:0]  amount;
    } entry_t;

    typedef struct packed {
        logic ins;
        logic rem;
    } cell_ctrl_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    tag;
        logic [AMT_W-1:0]    base;
        logic                late;
        logic [CNT_W-1:0]    count;
    } rslt_t;

    // year, month, day packed so that a plain compare orders dates
    function automatic logic [DATE_W-1:0] pack_date(
        input logic [DAY_W-1:0]   day,
        input logic [MONTH_W-1:0] month,
        input logic [YEAR_W-1:0]  year
    );
        return {year, month, day};
    endfunction

endpackage

// ===== sv/dkpq_if.sv =====
interface dkpq_req_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [dkpq_pkg::TAG_W-1:0]   entry_tag;
    logic [dkpq_pkg::AMT_W-1:0]   amount_cents;
    logic [dkpq_pkg::DAY_W-1:0]   due_day;
    logic [dkpq_pkg::MONTH_W-1:0] due_month;
    logic [dkpq_pkg::YEAR_W-1:0]  due_year;
    logic [dkpq_pkg::DAY_W-1:0]   today_day;
    logic [dkpq_pkg::MONTH_W-1:0] today_month;
    logic [dkpq_pkg::YEAR_W-1:0]  today_year;

    modport source
    (
        output valid, op, entry_tag, amount_cents, due_day, due_month, due_year,
               today_day, today_month, today_year,
        input  ready
    );
    modport sink
    (
        input  valid, op, entry_tag, amount_cents, due_day, due_month, due_year,
               today_day, today_month, today_year,
        output ready
    );
endinterface

interface dkpq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dkpq_pkg::STATUS_W-1:0] status;
    logic [dkpq_pkg::TAG_W-1:0]    paid_tag;
    logic [dkpq_pkg::AMT_W-1:0]    base_amount;
    logic [dkpq_pkg::DUE_W-1:0]    amount_due;
    logic                          overdue;
    logic [dkpq_pkg::CNT_W-1:0]    entry_count;

    modport source
    (
        output valid, status, paid_tag, base_amount, amount_due, overdue, entry_count,
        input  ready
    );
    modport sink
    (
        input  valid, status, paid_tag, base_amount, amount_due, overdue, entry_count,
        output ready
    );
endinterface

interface dkpq_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [dkpq_pkg::CAP_W-1:0] data;

    modport source
    (
        output valid, data,
        input  ready
    );
    modport sink
    (
        input  valid, data,
        output ready
    );
endinterface

// ===== sv/dkpq_cell.sv =====
module dkpq_cell
(
    input  logic                 clk,
    input  dkpq_pkg::cell_ctrl_t ctrl,
    input  logic                 occ,
    input  dkpq_pkg::entry_t     new_entry,
    input  logic                 left_after,
    input  dkpq_pkg::entry_t     left_entry,
    input  dkpq_pkg::entry_t     right_entry,
    output dkpq_pkg::entry_t     entry,
    output logic                 after
);

    dkpq_pkg::entry_t entry_reg;
    dkpq_pkg::entry_t entry_next;

    // held entry sorts at or before the new one: it stays put
    assign after = occ && (entry_reg.key <= new_entry.key);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (!after)
            begin
                entry_next = left_after ? new_entry : left_entry;
            end
        end
        else if (ctrl.rem)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== sv/dkpq_fine.sv =====
module dkpq_fine
(
    input  logic                            clk,
    input  logic                            en,
    input  dkpq_pkg::rslt_t                 rslt_in,
    output dkpq_pkg::rslt_t                 rslt_out,
    output logic [dkpq_pkg::DUE_W-1:0]      amount_due
);

    dkpq_pkg::rslt_t                   rslt_reg;
    logic [dkpq_pkg::QUO_W-1:0]        quo_reg;
    logic [dkpq_pkg::PROD_W-1:0]       prod;
    logic [dkpq_pkg::DUE_W-1:0]        fine;

    // tenth of the amount by reciprocal multiply
    assign prod = dkpq_pkg::PROD_W'(rslt_in.base) * dkpq_pkg::PROD_W'(dkpq_pkg::FINE_RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rslt_reg <= rslt_in;
            quo_reg  <= prod[dkpq_pkg::FINE_SHIFT +: dkpq_pkg::QUO_W];
        end
    end

    assign fine       = rslt_reg.late ? dkpq_pkg::DUE_W'(quo_reg) : '0;
    assign amount_due = dkpq_pkg::DUE_W'(rslt_reg.base) + fine;
    assign rslt_out   = rslt_reg;

endmodule

// ===== sv/date_keyed_priority_queue_core.sv =====
// Sorted queue of bills keyed by due date (year, month, day), earliest at the head.
// Storage is a row of DEPTH cells; on an insert every cell compares its key with the
// new one in parallel and either holds, takes the new entry or takes its left
// neighbor, and on a remove every cell takes its right neighbor, so the queue is
// updated in the cycle the request is accepted. Equal dates keep arrival order.
// One request can be accepted every cycle while the response side keeps up. The
// response passes three register stages (capture stage, multiply stage for the
// one-tenth fine, output register) before it is valid. The multiply stage is there
// for the 24x24 reciprocal multiplier. A stalled response stops the request side.
// capacity_limit (reset 10) refuses inserts once that many entries are held; limits
// above DEPTH act as DEPTH and zero refuses every insert. Write it only while no
// request is in flight.
module date_keyed_priority_queue_core
#(
    parameter int DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    dkpq_cfg_if.sink   cfg,
    dkpq_req_if.sink   req,
    dkpq_rsp_if.source rsp
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > dkpq_pkg::CAP_W) ? CW : dkpq_pkg::CAP_W;

    // configuration and queue fill
    logic [dkpq_pkg::CAP_W-1:0] cap_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;

    // pipeline valids
    logic a_valid_reg;
    logic b_valid_reg;
    logic out_valid_reg;

    // pipeline payload
    dkpq_pkg::rslt_t               a_reg;
    dkpq_pkg::rslt_t               a_next;
    dkpq_pkg::rslt_t               b_rslt;
    logic [dkpq_pkg::DUE_W-1:0]    b_due;
    dkpq_pkg::rslt_t               out_reg;
    logic [dkpq_pkg::DUE_W-1:0]    out_due_reg;

    logic                  en;
    logic                  accept;
    logic                  full;
    logic                  empty;
    dkpq_pkg::cell_ctrl_t  ctrl;
    dkpq_pkg::entry_t      new_entry;
    logic [dkpq_pkg::DATE_W-1:0] today_key;

    dkpq_pkg::entry_t cell_entry [DEPTH];
    logic [DEPTH-1:0] cell_after;
    logic [DEPTH-1:0] cell_occ;

    // whole pipeline advances unless the response register is stalled
    assign en       = !out_valid_reg || rsp.ready;
    assign req.ready = en;
    assign accept   = req.valid && en;

    // configuration port never stalls
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= dkpq_pkg::CAP_RESET;
        end
        else if (cfg.valid)
        begin
            cap_reg <= cfg.data;
        end
    end

    // full and empty tests on the held count
    assign full  = (CMPW'(count_reg) >= CMPW'(cap_reg)) || (count_reg >= CW'(DEPTH));
    assign empty = (count_reg == '0);

    assign new_entry.key    = dkpq_pkg::pack_date(req.due_day, req.due_month, req.due_year);
    assign new_entry.tag    = req.entry_tag;
    assign new_entry.amount = req.amount_cents;
    assign today_key = dkpq_pkg::pack_date(req.today_day, req.today_month, req.today_year);

    assign ctrl.ins = accept && (req.op == dkpq_pkg::OP_INSERT) && !full;
    assign ctrl.rem = accept && (req.op == dkpq_pkg::OP_REMOVE) && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.rem)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // capture-stage result, zero payload unless a real remove
    always_comb
    begin
        a_next.tag   = '0;
        a_next.base  = '0;
        a_next.late  = 1'b0;
        a_next.count = dkpq_pkg::CNT_W'(count_next);
        if (req.op == dkpq_pkg::OP_INSERT)
        begin
            a_next.status = full ? dkpq_pkg::ST_FULL : dkpq_pkg::ST_INSERTED;
        end
        else if (empty)
        begin
            a_next.status = dkpq_pkg::ST_EMPTY;
        end
        else
        begin
            a_next.status = dkpq_pkg::ST_REMOVED;
            a_next.tag    = cell_entry[0].tag;
            a_next.base   = cell_entry[0].amount;
            a_next.late   = today_key > cell_entry[0].key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (en)
            begin
                a_valid_reg   <= accept;
                b_valid_reg   <= a_valid_reg;
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg       <= a_next;
            out_reg     <= b_rslt;
            out_due_reg <= b_due;
        end
    end

    // row of sorted cells, head at index 0
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            dkpq_pkg::entry_t left_e;
            dkpq_pkg::entry_t right_e;
            logic             left_a;

            assign cell_occ[i] = count_reg > CW'(i);

            if (i == 0)
            begin : g_head
                assign left_e = new_entry;
                assign left_a = 1'b1;
            end
            else
            begin : g_body
                assign left_e = cell_entry[i-1];
                assign left_a = cell_after[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign right_e = '0;
            end
            else
            begin : g_mid
                assign right_e = cell_entry[i+1];
            end

            dkpq_cell u_cell
            (
                .clk         (clk),
                .ctrl        (ctrl),
                .occ         (cell_occ[i]),
                .new_entry   (new_entry),
                .left_after  (left_a),
                .left_entry  (left_e),
                .right_entry (right_e),
                .entry       (cell_entry[i]),
                .after       (cell_after[i])
            );
        end
    endgenerate

    // fine multiply stage
    dkpq_fine u_fine
    (
        .clk        (clk),
        .en         (en),
        .rslt_in    (a_reg),
        .rslt_out   (b_rslt),
        .amount_due (b_due)
    );

    // response register
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.paid_tag    = out_reg.tag;
    assign rsp.base_amount = out_reg.base;
    assign rsp.amount_due  = out_due_reg;
    assign rsp.overdue     = out_reg.late;
    assign rsp.entry_count = out_reg.count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("held count above depth");

    a_stall_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |-> !req.ready)
        else $error("request taken while response stalled");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the queue");

    a_due_ge_base: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.amount_due >= dkpq_pkg::DUE_W'(rsp.base_amount)))
        else $error("amount due below base amount");
`endif

endmodule
